/* rtl/core/sha1s_pkg.sv */
// Shared types, codes and constants for the SHA-1 stream hasher.
package sha1s_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        status;
	} rsp_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} work_t;

	localparam logic [1:0] REQ_ABSORB  = 2'd0;
	localparam logic [1:0] REQ_FINAL   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam int NUM_WORDS = 5;
	localparam int ROUND_W   = 7;

	localparam word_t H_INIT [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam word_t K_0 = 32'h5A827999;
	localparam word_t K_1 = 32'h6ED9EBA1;
	localparam word_t K_2 = 32'h8F1BBCDC;
	localparam word_t K_3 = 32'hCA62C1D6;

	localparam logic [ROUND_W-1:0] T_SCHED = 7'd16;
	localparam logic [ROUND_W-1:0] T_PH1   = 7'd20;
	localparam logic [ROUND_W-1:0] T_PH2   = 7'd40;
	localparam logic [ROUND_W-1:0] T_PH3   = 7'd60;
	localparam logic [ROUND_W-1:0] T_LAST  = 7'd79;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] POS_LAST  = 6'd63;
	// length field starts at byte 56 (bit 448) of a block
	localparam logic [5:0] POS_PRELEN = 6'd55;
	localparam logic [2:0] LEN_LAST   = 3'd7;
	localparam logic [2:0] IDX_LAST   = 3'd4;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_COMP = 6'b000100,
		ST_FOLD = 6'b001000,
		ST_OUT  = 6'b010000,
		ST_ERR  = 6'b100000
	} state_t;

endpackage

/* rtl/core/sha1_stream_hasher.sv */
// SHA-1 stream hasher top level: byte intake, padding sequencer, round loop, digest output.
//
//  channel | direction | payload              | handshake
//  req     | in        | req_type, data_byte  | req_valid / req_stall
//  rsp     | out       | digest word + status | rsp_valid / rsp_stall
//
// A byte that fills the 64-byte block starts the 80 rounds of the shared round unit
// and then the chaining fold. Finalize feeds 9 to 72 padding bytes at one per cycle,
// pausing for one or two block compressions, then presents the five digest words one
// per taken word. Requests are stalled whenever the sequencer is not idle. Reset is
// asynchronous and sets the initial chaining words at once; no clearing pass.
module sha1_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  sha1s_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output sha1s_pkg::rsp_t   rsp
);

	sha1s_pkg::state_t state_q;
	logic [511:0]      blk_q;
	logic [63:0]       bitlen_q;
	logic [63:0]       len_q;
	sha1s_pkg::word_t  chain_q [sha1s_pkg::NUM_WORDS];
	sha1s_pkg::work_t  work_q;
	logic [sha1s_pkg::ROUND_W-1:0] round_q;
	logic              mark_q;
	logic              lenph_q;
	logic [2:0]        lencnt_q;
	logic              tail_q;
	logic              fin_q;
	logic [2:0]        idx_q;
	logic              done_q;

	logic              take_byte;
	logic [7:0]        byte_val;
	logic              start_comp;
	logic              start_fin;
	logic [5:0]        pos;
	sha1s_pkg::work_t  chain_work;
	sha1s_pkg::work_t  round_nxt;
	sha1s_pkg::word_t  w_new;

	assign pos = bitlen_q[8:3];

	assign chain_work = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
	                      d: chain_q[3], e: chain_q[4]};

	always_comb begin
		take_byte = 1'b0;
		start_fin = 1'b0;
		byte_val  = req.data_byte;
		if (state_q == sha1s_pkg::ST_IDLE) begin
			if (req_valid && !done_q && req.req_type == sha1s_pkg::REQ_ABSORB) begin
				take_byte = 1'b1;
			end
			if (req_valid && !done_q && req.req_type == sha1s_pkg::REQ_FINAL) begin
				start_fin = 1'b1;
			end
		end else if (state_q == sha1s_pkg::ST_PAD) begin
			take_byte = 1'b1;
			if (mark_q) begin
				byte_val = sha1s_pkg::PAD_MARK;
			end else if (lenph_q) begin
				byte_val = len_q[63:56];
			end else begin
				byte_val = 8'h00;
			end
		end
		start_comp = take_byte && (pos == sha1s_pkg::POS_LAST);
	end

	sha1s_round u_round (
		.round    (round_q),
		.cur      (work_q),
		.w_slot0  (blk_q[511:480]),
		.w_slot2  (blk_q[447:416]),
		.w_slot8  (blk_q[255:224]),
		.w_slot13 (blk_q[95:64]),
		.w_new    (w_new),
		.nxt      (round_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha1s_pkg::ST_IDLE;
			bitlen_q <= '0;
			for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
				chain_q[i] <= sha1s_pkg::H_INIT[i];
			end
			round_q  <= '0;
			mark_q   <= 1'b0;
			lenph_q  <= 1'b0;
			lencnt_q <= '0;
			tail_q   <= 1'b0;
			fin_q    <= 1'b0;
			idx_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			if (take_byte) begin
				bitlen_q <= bitlen_q + 64'd8;
			end
			if (start_comp) begin
				round_q <= '0;
				state_q <= sha1s_pkg::ST_COMP;
			end
			case (state_q)
				sha1s_pkg::ST_IDLE: begin
					if (req_valid) begin
						case (req.req_type)
							sha1s_pkg::REQ_RESTART: begin
								bitlen_q <= '0;
								done_q   <= 1'b0;
								for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
									chain_q[i] <= sha1s_pkg::H_INIT[i];
								end
							end
							sha1s_pkg::REQ_ABSORB: begin
								fin_q <= 1'b0;
								if (done_q) begin
									state_q <= sha1s_pkg::ST_ERR;
								end
							end
							sha1s_pkg::REQ_FINAL: begin
								if (done_q) begin
									state_q <= sha1s_pkg::ST_ERR;
								end else begin
									fin_q    <= 1'b1;
									mark_q   <= 1'b1;
									lenph_q  <= 1'b0;
									lencnt_q <= '0;
									tail_q   <= 1'b0;
									state_q  <= sha1s_pkg::ST_PAD;
								end
							end
							default: ;
						endcase
					end
				end
				sha1s_pkg::ST_PAD: begin
					mark_q <= 1'b0;
					if (lenph_q) begin
						lencnt_q <= lencnt_q + 3'd1;
						if (lencnt_q == sha1s_pkg::LEN_LAST) begin
							tail_q <= 1'b1;
						end
					end else if (pos == sha1s_pkg::POS_PRELEN) begin
						lenph_q <= 1'b1;
					end
				end
				sha1s_pkg::ST_COMP: begin
					round_q <= round_q + 7'd1;
					if (round_q == sha1s_pkg::T_LAST) begin
						state_q <= sha1s_pkg::ST_FOLD;
					end
				end
				sha1s_pkg::ST_FOLD: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					if (!fin_q) begin
						state_q <= sha1s_pkg::ST_IDLE;
					end else if (tail_q) begin
						idx_q   <= '0;
						state_q <= sha1s_pkg::ST_OUT;
					end else begin
						state_q <= sha1s_pkg::ST_PAD;
					end
				end
				sha1s_pkg::ST_OUT: begin
					if (!rsp_stall) begin
						if (idx_q == sha1s_pkg::IDX_LAST) begin
							done_q  <= 1'b1;
							fin_q   <= 1'b0;
							state_q <= sha1s_pkg::ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				sha1s_pkg::ST_ERR: begin
					if (!rsp_stall) begin
						state_q <= sha1s_pkg::ST_IDLE;
					end
				end
				default: state_q <= sha1s_pkg::ST_IDLE;
			endcase
		end
	end

	// block buffer doubles as the 16-word schedule window during rounds
	always_ff @(posedge clk) begin
		if (take_byte) begin
			blk_q <= {blk_q[503:0], byte_val};
		end else if (state_q == sha1s_pkg::ST_COMP) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (start_comp) begin
			work_q <= chain_work;
		end else if (state_q == sha1s_pkg::ST_COMP) begin
			work_q <= round_nxt;
		end
		if (start_fin) begin
			len_q <= bitlen_q;
		end else if (state_q == sha1s_pkg::ST_PAD && lenph_q) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	assign req_stall = (state_q != sha1s_pkg::ST_IDLE);
	assign rsp_valid = (state_q == sha1s_pkg::ST_OUT) || (state_q == sha1s_pkg::ST_ERR);

	always_comb begin
		if (state_q == sha1s_pkg::ST_ERR) begin
			rsp.digest_word = '0;
			rsp.word_index  = '0;
			rsp.last_word   = 1'b1;
			rsp.status      = 1'b1;
		end else begin
			rsp.digest_word = chain_q[idx_q];
			rsp.word_index  = idx_q;
			rsp.last_word   = (idx_q == sha1s_pkg::IDX_LAST);
			rsp.status      = 1'b0;
		end
	end

endmodule

/* rtl/core/sha1s_round.sv */
// One SHA-1 round with message schedule expansion, reused for all 80 rounds.
module sha1s_round (
	input  logic [sha1s_pkg::ROUND_W-1:0] round,
	input  sha1s_pkg::work_t              cur,
	input  sha1s_pkg::word_t              w_slot0,
	input  sha1s_pkg::word_t              w_slot2,
	input  sha1s_pkg::word_t              w_slot8,
	input  sha1s_pkg::word_t              w_slot13,
	output sha1s_pkg::word_t              w_new,
	output sha1s_pkg::work_t              nxt
);

	sha1s_pkg::word_t x;
	sha1s_pkg::word_t f;
	sha1s_pkg::word_t k;
	sha1s_pkg::word_t tmp;

	always_comb begin
		x = w_slot13 ^ w_slot8 ^ w_slot2 ^ w_slot0;
		if (round < sha1s_pkg::T_SCHED) begin
			w_new = w_slot0;
		end else begin
			w_new = {x[30:0], x[31]};
		end

		if (round < sha1s_pkg::T_PH1) begin
			f = (cur.b & (cur.c ^ cur.d)) ^ cur.d;
			k = sha1s_pkg::K_0;
		end else if (round < sha1s_pkg::T_PH2) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1s_pkg::K_1;
		end else if (round < sha1s_pkg::T_PH3) begin
			f = ((cur.b | cur.c) & cur.d) | (cur.b & cur.c);
			k = sha1s_pkg::K_2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1s_pkg::K_3;
		end

		tmp   = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w_new;
		nxt.a = tmp;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

/* rtl/core/sha1s_checker.sv */
// Port-level assertions for the SHA-1 stream hasher, bound to the top level.
module sha1s_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input sha1s_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input sha1s_pkg::rsp_t rsp
);

	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while a result word is pending");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |->
			rsp.last_word && rsp.digest_word == 32'd0 && rsp.word_index == 3'd0)
		else $error("malformed rejection word");

	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.status |->
			rsp.word_index <= 3'd4 && (rsp.last_word == (rsp.word_index == 3'd4)))
		else $error("digest word index and last flag disagree");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last_word |=>
			rsp_valid && rsp.word_index == $past(rsp.word_index) + 3'd1)
		else $error("digest words not sent in order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);
